// ----- design/srb_pkg.sv -----
// Package for the serial receive/transmit byte rings.
// Holds ring depths, field widths, action codes and channel payload types.
// No dependencies.
package srb_pkg;

  localparam int unsigned RX_DEPTH = 64;
  localparam int unsigned TX_DEPTH = 64;

  localparam int unsigned RX_PTR_W = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TX_PTR_W = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 6;

  localparam logic [ACT_W-1:0] ACT_RX_BYTE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEND    = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
  } srb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              rx_dropped;
    logic              write_refused;
    logic [STAT_W-1:0] rx_count;
    logic [STAT_W-1:0] tx_space;
    logic              tx_irq_on;
  } srb_out_t;

endpackage

// ----- design/srb_chan_if.sv -----
// Valid/ready channel interfaces for the ring buffer requests and results.
// Depends on srb_pkg for the payload types.
interface srb_in_if import srb_pkg::*; ();
  logic    valid;
  logic    ready;
  srb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srb_out_if import srb_pkg::*; ();
  logic     valid;
  logic     ready;
  srb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/srb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 2) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 2) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/serial_rx_tx_ring_buffers_unit.sv -----
// Top level of the serial receive/transmit byte rings.
// Depends on srb_pkg, srb_chan_if and srb_ram.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    action, data_byte
//   out_o    out  valid/ready    out_byte, out_valid, rx_dropped, write_refused,
//                                rx_count, tx_space, tx_irq_on
//
// One request per cycle unless a result stalls. Its result is registered in the
// cycle after acceptance, the byte from the registered read port of a ring RAM.
// Reset clears both rings' pointers, the interrupt flag and the output valid;
// RAM contents are not cleared. A stalled result holds; a new request is taken
// in the same cycle the pending result is taken.
module serial_rx_tx_ring_buffers_unit import srb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  srb_in_if.sink    in_i,
  srb_out_if.source out_o
);

  localparam int unsigned RX_FILL_W = (RX_PTR_W + 1 > STAT_W) ? RX_PTR_W + 1 : STAT_W;
  localparam int unsigned TX_FILL_W = (TX_PTR_W + 1 > STAT_W) ? TX_PTR_W + 1 : STAT_W;

  typedef struct packed {
    logic              byte_ok;
    logic              src_tx;
    logic              dropped;
    logic              refused;
    logic [STAT_W-1:0] rx_count;
    logic [STAT_W-1:0] tx_space;
    logic              irq;
  } res_t;

  function automatic logic [RX_PTR_W-1:0] rx_inc(input logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_inc(input logic [TX_PTR_W-1:0] p);
    return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + TX_PTR_W'(1);
  endfunction

  logic [RX_PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [TX_PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic                irq_q, irq_d;
  logic                ovld_q, ovld_d;
  res_t                res_q, res_d;

  logic                accept;
  logic                rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0]   rx_rdata, tx_rdata;
  logic [RX_FILL_W-1:0] rx_fill;
  logic [TX_FILL_W-1:0] tx_used, tx_free;
  logic [ACT_W-1:0]    act;

  assign in_i.ready = !ovld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = in_i.data.action;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    irq_d     = irq_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    res_d     = '0;
    case (act)
      ACT_RX_BYTE: begin
        if (rx_inc(rx_head_q) != rx_tail_q) begin
          rx_we     = accept;
          rx_head_d = rx_inc(rx_head_q);
        end else begin
          res_d.dropped = 1'b1;
        end
      end
      ACT_READ, ACT_PEEK: begin
        if (rx_head_q != rx_tail_q) begin
          rx_re         = accept;
          res_d.byte_ok = 1'b1;
          if (act == ACT_READ) begin
            rx_tail_d = rx_inc(rx_tail_q);
          end
        end
      end
      ACT_WRITE: begin
        if (tx_inc(tx_head_q) == tx_tail_q) begin
          res_d.refused = 1'b1;
        end else begin
          tx_we     = accept;
          tx_head_d = tx_inc(tx_head_q);
          irq_d     = 1'b1;
        end
      end
      ACT_SEND: begin
        if (tx_head_q != tx_tail_q) begin
          tx_re         = accept;
          res_d.byte_ok = 1'b1;
          res_d.src_tx  = 1'b1;
          tx_tail_d     = tx_inc(tx_tail_q);
        end
        if (tx_head_q == tx_tail_d) begin
          irq_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (rx_head_d >= rx_tail_d) begin
      rx_fill = RX_FILL_W'(rx_head_d) - RX_FILL_W'(rx_tail_d);
    end else begin
      rx_fill = RX_FILL_W'(rx_head_d) + RX_FILL_W'(RX_DEPTH) - RX_FILL_W'(rx_tail_d);
    end
    if (tx_head_d >= tx_tail_d) begin
      tx_used = TX_FILL_W'(tx_head_d) - TX_FILL_W'(tx_tail_d);
    end else begin
      tx_used = TX_FILL_W'(tx_head_d) + TX_FILL_W'(TX_DEPTH) - TX_FILL_W'(tx_tail_d);
    end
    tx_free = TX_FILL_W'(TX_DEPTH - 1) - tx_used;

    res_d.rx_count = rx_fill[STAT_W-1:0];
    res_d.tx_space = tx_free[STAT_W-1:0];
    res_d.irq      = irq_d;

    ovld_d = accept ? 1'b1 : (out_o.ready ? 1'b0 : ovld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      irq_q     <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      if (accept) begin
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        irq_q     <= irq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  srb_ram #(
    .Width (BYTE_W),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (in_i.data.data_byte),
    .re_i    (rx_re),
    .raddr_i (rx_tail_q),
    .rdata_o (rx_rdata)
  );

  srb_ram #(
    .Width (BYTE_W),
    .Depth (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (in_i.data.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  assign out_o.valid              = ovld_q;
  assign out_o.data.out_byte      = !res_q.byte_ok ? '0 : (res_q.src_tx ? tx_rdata : rx_rdata);
  assign out_o.data.out_valid     = res_q.byte_ok;
  assign out_o.data.rx_dropped    = res_q.dropped;
  assign out_o.data.write_refused = res_q.refused;
  assign out_o.data.rx_count      = res_q.rx_count;
  assign out_o.data.tx_space      = res_q.tx_space;
  assign out_o.data.tx_irq_on     = res_q.irq;

endmodule
